// ===== design/pfsh_pkg.sv =====
// Shared types and constants for the fan-sum histogrammer.
// No dependencies; the top, event check and controller refer to this package by scoped name.
`default_nettype none

package pfsh_pkg;

  localparam int unsigned RINGS_DEF      = 64;
  localparam int unsigned DET_PER_RING_DEF = 512;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [5:0] RING_DIFF_LIMIT_RST = 6'd63;
  localparam logic [8:0] HALF_FAN_RST        = 9'd256;

  typedef enum logic [1:0] {
    OP_TIME  = 2'd0,
    OP_EVENT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_START     = 3'd0,
    CFG_FRAME_END       = 3'd1,
    CFG_RING_DIFF_LIMIT = 3'd2,
    CFG_HALF_FAN        = 3'd3,
    CFG_COUNT_PROMPTS   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] frame_start;
    logic [31:0] frame_end;
    logic [5:0]  ring_diff_limit;
    logic [8:0]  half_fan;
    logic        count_prompts;
  } cfg_t;

  // Verdict from the event check towards the controller
  typedef struct packed {
    logic count_ok;
    logic read_ok;
  } chk_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_UPD_A,
    ST_UPD_B,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/pet_fan_sum_histogrammer_top.sv =====
// Fan-sum histogrammer top: configuration registers, controller and histogram RAM.
// Depends on pfsh_pkg, pfsh_ram, pfsh_hist_ctrl.
// A counted event passes EXEC, UPD_A and UPD_B (two RMW passes on one RAM), then DONE;
//   other records pass EXEC and DONE, and a clear sweeps all RINGS*DETECTORS_PER_RING bins first.
// Only one record is in flight; in_stall holds new records until its result has been registered.
// Reset (sync): config defaults, time and done flag zeroed, then RINGS*DETECTORS_PER_RING sweep.
`default_nettype none

module pet_fan_sum_histogrammer_top #(
  parameter int unsigned RINGS              = pfsh_pkg::RINGS_DEF,
  parameter int unsigned DETECTORS_PER_RING = pfsh_pkg::DET_PER_RING_DEF,
  parameter int unsigned COUNT_BITS         = pfsh_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      operation,
  input  wire logic [31:0]                     time_ms,
  input  wire logic                            prompt_kind,
  input  wire logic [5:0]                      ring_first,
  input  wire logic [8:0]                      det_first,
  input  wire logic [5:0]                      ring_second,
  input  wire logic [8:0]                      det_second,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [31:0]                          bin_count,
  output logic                                 accepted,
  output logic                                 frame_done,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pfsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfsh_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned NUM_BINS = RINGS * DETECTORS_PER_RING;
  localparam int unsigned ADDR_W   = $clog2(NUM_BINS);

  pfsh_pkg::cfg_t        cfg;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_start     <= '0;
      cfg.frame_end       <= '0;
      cfg.ring_diff_limit <= pfsh_pkg::RING_DIFF_LIMIT_RST;
      cfg.half_fan        <= pfsh_pkg::HALF_FAN_RST;
      cfg.count_prompts   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (pfsh_pkg::cfg_idx_t'(cfg_index))
        pfsh_pkg::CFG_FRAME_START:     cfg.frame_start     <= cfg_data[31:0];
        pfsh_pkg::CFG_FRAME_END:       cfg.frame_end       <= cfg_data[31:0];
        pfsh_pkg::CFG_RING_DIFF_LIMIT: cfg.ring_diff_limit <= cfg_data[5:0];
        pfsh_pkg::CFG_HALF_FAN:        cfg.half_fan        <= cfg_data[8:0];
        pfsh_pkg::CFG_COUNT_PROMPTS:   cfg.count_prompts   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfsh_hist_ctrl #(
    .RINGS              (RINGS),
    .DETECTORS_PER_RING (DETECTORS_PER_RING),
    .COUNT_BITS         (COUNT_BITS),
    .ADDR_W             (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .time_ms     (time_ms),
    .prompt_kind (prompt_kind),
    .ring_first  (ring_first),
    .det_first   (det_first),
    .ring_second (ring_second),
    .det_second  (det_second),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_count   (bin_count),
    .accepted    (accepted),
    .frame_done  (frame_done),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  pfsh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== design/pfsh_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents. No dependencies.
`default_nettype none

module pfsh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/pfsh_event_check.sv =====
// Event qualification and bin addressing: ring window, transaxial fan, frame and kind.
// Depends on pfsh_pkg.
`default_nettype none

module pfsh_event_check #(
  parameter int unsigned RINGS              = pfsh_pkg::RINGS_DEF,
  parameter int unsigned DETECTORS_PER_RING = pfsh_pkg::DET_PER_RING_DEF,
  parameter int unsigned ADDR_W             = 15
) (
  input  pfsh_pkg::cfg_t          cfg,
  input  wire logic               done_flag,
  input  wire logic [31:0]        time_now,
  input  wire logic               prompt_kind,
  input  wire logic [5:0]         ring_first,
  input  wire logic [8:0]         det_first,
  input  wire logic [5:0]         ring_second,
  input  wire logic [8:0]         det_second,
  output pfsh_pkg::chk_t          chk,
  output logic [ADDR_W-1:0]       addr_a,
  output logic [ADDR_W-1:0]       addr_b
);

  localparam int unsigned FW  = $clog2(3 * DETECTORS_PER_RING + 512) + 1;
  localparam int unsigned H3  = (3 * DETECTORS_PER_RING) / 2;
  localparam int unsigned N2  = 2 * DETECTORS_PER_RING;

  logic          ring_a_ok, ring_b_ok, det_a_ok, det_b_ok;
  logic [5:0]    ring_diff;
  logic [FW-1:0] fan_sum, fan_red, fan_d;
  logic          fan_ok;

  assign ring_a_ok = 32'(ring_first)  < RINGS;
  assign ring_b_ok = 32'(ring_second) < RINGS;
  assign det_a_ok  = 32'(det_first)   < DETECTORS_PER_RING;
  assign det_b_ok  = 32'(det_second)  < DETECTORS_PER_RING;

  assign ring_diff = (ring_first > ring_second) ? ring_first - ring_second
                                                : ring_second - ring_first;

  // Offset from the opposite detector, folded into [0, N) by two conditional subtracts
  assign fan_sum = FW'(det_first) + FW'(H3) - FW'(det_second);
  assign fan_red = (fan_sum >= FW'(N2)) ? fan_sum - FW'(N2) : fan_sum;
  assign fan_d   = (fan_red >= FW'(DETECTORS_PER_RING)) ?
                   fan_red - FW'(DETECTORS_PER_RING) : fan_red;
  assign fan_ok  = (fan_d <= FW'(cfg.half_fan)) ||
                   ((fan_d + FW'(cfg.half_fan)) >= FW'(DETECTORS_PER_RING));

  assign chk.count_ok = !done_flag && (prompt_kind == cfg.count_prompts) &&
                        (cfg.frame_start <= time_now) &&
                        ring_a_ok && ring_b_ok && det_a_ok && det_b_ok &&
                        (ring_diff <= cfg.ring_diff_limit) && fan_ok;
  assign chk.read_ok  = ring_a_ok && det_a_ok;

  assign addr_a = ADDR_W'(32'(ring_first) * 32'(DETECTORS_PER_RING) + 32'(det_first));
  assign addr_b = ADDR_W'(32'(ring_second) * 32'(DETECTORS_PER_RING) + 32'(det_second));

endmodule

`default_nettype wire

// ===== design/pfsh_hist_ctrl.sv =====
// Sequencer for the histogram: clearing sweep, read-modify-write of both bins,
// bin reads, frame timing and the result register. Depends on pfsh_pkg, pfsh_event_check.
`default_nettype none

module pfsh_hist_ctrl #(
  parameter int unsigned RINGS              = pfsh_pkg::RINGS_DEF,
  parameter int unsigned DETECTORS_PER_RING = pfsh_pkg::DET_PER_RING_DEF,
  parameter int unsigned COUNT_BITS         = pfsh_pkg::COUNT_BITS_DEF,
  parameter int unsigned ADDR_W             = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  pfsh_pkg::cfg_t             cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [31:0]           time_ms,
  input  wire logic                  prompt_kind,
  input  wire logic [5:0]            ring_first,
  input  wire logic [8:0]            det_first,
  input  wire logic [5:0]            ring_second,
  input  wire logic [8:0]            det_second,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                bin_count,
  output logic                       accepted,
  output logic                       frame_done,
  output logic                       mem_we,
  output logic [ADDR_W-1:0]          mem_waddr,
  output logic [COUNT_BITS-1:0]      mem_wdata,
  output logic                       mem_re,
  output logic [ADDR_W-1:0]          mem_raddr,
  input  wire logic [COUNT_BITS-1:0] mem_rdata
);

  localparam int unsigned NUM_BINS = RINGS * DETECTORS_PER_RING;
  localparam int unsigned XW       = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  pfsh_pkg::state_t state, state_next;

  // Held item
  pfsh_pkg::op_t    op;
  logic [31:0]      item_time;
  logic             item_prompt;
  logic [5:0]       item_ring_a, item_ring_b;
  logic [8:0]       item_det_a, item_det_b;

  logic [31:0]      time_now;
  logic             done_flag;
  logic [ADDR_W-1:0] clr_addr;
  logic             clr_owed;
  logic             acc;
  logic [COUNT_BITS-1:0] upd_val;

  pfsh_pkg::chk_t    chk;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              in_xfer, out_free, clr_last;
  logic [COUNT_BITS-1:0] inc_a, base_b, inc_b;
  logic [XW-1:0]     rd_ext;
  logic [31:0]       rd_clip;

  pfsh_event_check #(
    .RINGS              (RINGS),
    .DETECTORS_PER_RING (DETECTORS_PER_RING),
    .ADDR_W             (ADDR_W)
  ) u_check (
    .cfg          (cfg),
    .done_flag    (done_flag),
    .time_now     (time_now),
    .prompt_kind  (item_prompt),
    .ring_first   (item_ring_a),
    .det_first    (item_det_a),
    .ring_second  (item_ring_b),
    .det_second   (item_det_b),
    .chk          (chk),
    .addr_a       (addr_a),
    .addr_b       (addr_b)
  );

  assign in_stall = (state != pfsh_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clr_last = (clr_addr == ADDR_W'(NUM_BINS - 1));

  // Saturating increments; the second bin takes the first's new value when both coincide
  assign inc_a  = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
  assign base_b = (addr_a == addr_b) ? upd_val : mem_rdata;
  assign inc_b  = (&base_b) ? base_b : base_b + COUNT_BITS'(1);

  assign rd_ext  = XW'(mem_rdata);
  assign rd_clip = (rd_ext > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : rd_ext[31:0];

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = addr_a;
    mem_wdata  = inc_a;
    mem_re     = 1'b0;
    mem_raddr  = addr_a;
    case (state)
      pfsh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_last) begin
          state_next = clr_owed ? pfsh_pkg::ST_DONE : pfsh_pkg::ST_IDLE;
        end
      end
      pfsh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = pfsh_pkg::ST_EXEC;
        end
      end
      pfsh_pkg::ST_EXEC: begin
        case (op)
          pfsh_pkg::OP_EVENT: begin
            mem_re     = chk.count_ok;
            state_next = chk.count_ok ? pfsh_pkg::ST_UPD_A : pfsh_pkg::ST_DONE;
          end
          pfsh_pkg::OP_READ: begin
            mem_re     = chk.read_ok;
            state_next = pfsh_pkg::ST_DONE;
          end
          pfsh_pkg::OP_CLEAR: state_next = pfsh_pkg::ST_CLEAR;
          default:            state_next = pfsh_pkg::ST_DONE;
        endcase
      end
      pfsh_pkg::ST_UPD_A: begin
        mem_we     = 1'b1;
        mem_re     = 1'b1;
        mem_raddr  = addr_b;
        state_next = pfsh_pkg::ST_UPD_B;
      end
      pfsh_pkg::ST_UPD_B: begin
        mem_we     = 1'b1;
        mem_waddr  = addr_b;
        mem_wdata  = inc_b;
        state_next = pfsh_pkg::ST_DONE;
      end
      pfsh_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pfsh_pkg::ST_IDLE;
        end
      end
      default: state_next = pfsh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfsh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now     <= '0;
      done_flag    <= 1'b0;
      clr_addr     <= '0;
      clr_owed     <= 1'b0;
      acc          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == pfsh_pkg::ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + ADDR_W'(1);
      end
      if (state == pfsh_pkg::ST_EXEC) begin
        acc      <= (op == pfsh_pkg::OP_EVENT) && chk.count_ok;
        clr_owed <= (op == pfsh_pkg::OP_CLEAR);
        if (op == pfsh_pkg::OP_TIME && !done_flag) begin
          if (cfg.frame_end > cfg.frame_start && item_time >= cfg.frame_end) begin
            done_flag <= 1'b1;
          end else begin
            time_now <= item_time;
          end
        end
      end
      if (state == pfsh_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: item capture, forwarded bin value, result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op          <= pfsh_pkg::op_t'(operation);
      item_time   <= time_ms;
      item_prompt <= prompt_kind;
      item_ring_a <= ring_first;
      item_det_a  <= det_first;
      item_ring_b <= ring_second;
      item_det_b  <= det_second;
    end
    if (state == pfsh_pkg::ST_UPD_A) begin
      upd_val <= inc_a;
    end
    if (state == pfsh_pkg::ST_DONE && out_free) begin
      bin_count  <= (op == pfsh_pkg::OP_READ && chk.read_ok) ? rd_clip : 32'd0;
      accepted   <= acc;
      frame_done <= done_flag;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/fan_sum_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the fan-sum histogrammer: follows register writes and record
// transfers, keeps its own histogram, time and done flag, and compares every result.
// Depends on pfsh_pkg.
module fan_sum_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      operation,
  input  logic [31:0]                     time_ms,
  input  logic                            prompt_kind,
  input  logic [5:0]                      ring_first,
  input  logic [8:0]                      det_first,
  input  logic [5:0]                      ring_second,
  input  logic [8:0]                      det_second,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [31:0]                     bin_count,
  input  logic                            accepted,
  input  logic                            frame_done,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pfsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfsh_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              counted_events,
  output int                              nonzero_reads
);

  localparam int DETS = pfsh_pkg::DET_PER_RING_DEF;

  typedef struct packed {
    logic [31:0] bin_count;
    logic        accepted;
    logic        frame_done;
  } fan_result_t;

  logic [31:0]    fan_sums [int unsigned];
  logic [31:0]    now_ms;
  logic           done_seen;
  pfsh_pkg::cfg_t regs;
  fan_result_t    due_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
    counted_events = 0;
    nonzero_reads = 0;
  end

  function automatic void add_hit(int unsigned bin);
    if (!fan_sums.exists(bin)) fan_sums[bin] = '0;
    if (fan_sums[bin] != '1) fan_sums[bin] = fan_sums[bin] + 1;
  endfunction

  function automatic fan_result_t predict_fan_sum(pfsh_pkg::op_t op, logic [31:0] t,
      logic prompt, logic [5:0] rf, logic [8:0] df, logic [5:0] rs, logic [8:0] ds);
    fan_result_t res;
    int          ring_gap;
    int          fan_offset;
    int unsigned bin_a;
    int unsigned bin_b;
    res = '0;
    bin_a = int'(rf) * DETS + int'(df);
    bin_b = int'(rs) * DETS + int'(ds);
    case (op)
      pfsh_pkg::OP_TIME: begin
        // marks are ignored once the frame has ended
        if (!done_seen) begin
          if (regs.frame_end > regs.frame_start && t >= regs.frame_end) done_seen = 1'b1;
          else now_ms = t;
        end
      end
      pfsh_pkg::OP_EVENT: begin
        ring_gap = (rf > rs) ? int'(rf) - int'(rs) : int'(rs) - int'(rf);
        // offset from the detector straight across the ring
        fan_offset = (int'(df) - int'(ds) + 3 * DETS / 2) % DETS;
        if (!done_seen && prompt == regs.count_prompts && regs.frame_start <= now_ms
            && ring_gap <= int'(regs.ring_diff_limit)
            && (fan_offset <= int'(regs.half_fan)
                || fan_offset >= DETS - int'(regs.half_fan))) begin
          add_hit(bin_a);
          add_hit(bin_b);
          res.accepted = 1'b1;
        end
      end
      pfsh_pkg::OP_READ: begin
        if (fan_sums.exists(bin_a)) res.bin_count = fan_sums[bin_a];
      end
      default: fan_sums.delete();
    endcase
    res.frame_done = done_seen;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    fan_result_t want;
    if (rst) begin
      fan_sums.delete();
      due_results.delete();
      now_ms = '0;
      done_seen = 1'b0;
      regs.frame_start = '0;
      regs.frame_end = '0;
      regs.ring_diff_limit = pfsh_pkg::RING_DIFF_LIMIT_RST;
      regs.half_fan = pfsh_pkg::HALF_FAN_RST;
      regs.count_prompts = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pfsh_pkg::cfg_idx_t'(cfg_index))
          pfsh_pkg::CFG_FRAME_START:     regs.frame_start = cfg_data;
          pfsh_pkg::CFG_FRAME_END:       regs.frame_end = cfg_data;
          pfsh_pkg::CFG_RING_DIFF_LIMIT: regs.ring_diff_limit = cfg_data[5:0];
          pfsh_pkg::CFG_HALF_FAN:        regs.half_fan = cfg_data[8:0];
          pfsh_pkg::CFG_COUNT_PROMPTS:   regs.count_prompts = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing due, got bin_count %0d accepted %0d frame_done %0d",
                   $time, bin_count, accepted, frame_done);
        end else begin
          want = due_results.pop_front();
          check_field("bin_count", want.bin_count, bin_count);
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("frame_done", 32'(want.frame_done), 32'(frame_done));
          if (want.accepted) counted_events++;
          if (want.bin_count != 0) nonzero_reads++;
        end
      end
      if (in_valid && !in_stall) begin
        due_results.insert(due_results.size(),
                           predict_fan_sum(pfsh_pkg::op_t'(operation), time_ms, prompt_kind,
                                           ring_first, det_first, ring_second, det_second));
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/sv/tb_pet_fan_sum_histogrammer_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the fan-sum histogrammer: drives list-mode records and register
// writes under several idling patterns and reports the verdict.
// Depends on pfsh_pkg, pet_fan_sum_histogrammer_top and fan_sum_checker.
module tb_pet_fan_sum_histogrammer_top;

  localparam int QUIET_LIMIT = 100000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      operation = pfsh_pkg::OP_TIME;
  logic [31:0]                     time_ms = '0;
  logic                            prompt_kind = 1'b0;
  logic [5:0]                      ring_first = '0;
  logic [8:0]                      det_first = '0;
  logic [5:0]                      ring_second = '0;
  logic [8:0]                      det_second = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [31:0]                     bin_count;
  logic                            accepted;
  logic                            frame_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pfsh_pkg::CFG_IDX_W-1:0]  cfg_index = pfsh_pkg::CFG_FRAME_START;
  logic [pfsh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int counted_events;
  int nonzero_reads;

  // register values as last written, used to shape well-formed records
  logic [31:0] st_start = '0;
  logic [31:0] st_end = '0;
  int          st_ring_diff = 63;
  int          st_half_fan = 256;
  logic        st_prompts = 1'b0;

  int          gap_pct = 0;
  int          stall_pct = 0;
  int          clears_left = 3;
  int          n_records = 0;
  int          quiet_cycles = 0;
  logic [5:0]  recent_ring [16];
  logic [8:0]  recent_det [16];
  int          recent_next = 0;

  always #4 clk = ~clk;

  pet_fan_sum_histogrammer_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .time_ms(time_ms), .prompt_kind(prompt_kind),
    .ring_first(ring_first), .det_first(det_first),
    .ring_second(ring_second), .det_second(det_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_count(bin_count), .accepted(accepted), .frame_done(frame_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fan_sum_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .time_ms(time_ms), .prompt_kind(prompt_kind),
    .ring_first(ring_first), .det_first(det_first),
    .ring_second(ring_second), .det_second(det_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_count(bin_count), .accepted(accepted), .frame_done(frame_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .counted_events(counted_events), .nonzero_reads(nonzero_reads)
  );

  always @(negedge clk) out_stall <= ($urandom_range(99, 0) < stall_pct);

  // end the run when nothing has moved for far longer than a clear sweep
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_record(pfsh_pkg::op_t op, logic [31:0] t, logic prompt, logic [5:0] rf,
                             logic [8:0] df, logic [5:0] rs, logic [8:0] ds);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    operation <= op;
    time_ms <= t;
    prompt_kind <= prompt;
    ring_first <= rf;
    det_first <= df;
    ring_second <= rs;
    det_second <= ds;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_records++;
  endtask

  task automatic write_reg(pfsh_pkg::cfg_idx_t idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_frame(logic [31:0] start, logic [31:0] stop, int ring_diff, int half,
                            logic prompts);
    write_reg(pfsh_pkg::CFG_FRAME_START, start);
    write_reg(pfsh_pkg::CFG_FRAME_END, stop);
    write_reg(pfsh_pkg::CFG_RING_DIFF_LIMIT, ring_diff);
    write_reg(pfsh_pkg::CFG_HALF_FAN, half);
    write_reg(pfsh_pkg::CFG_COUNT_PROMPTS, 32'(prompts));
    cfg_valid <= 1'b0;
    st_start = start;
    st_end = stop;
    st_ring_diff = ring_diff;
    st_half_fan = half;
    st_prompts = prompts;
  endtask

  // drop valid and drain every outstanding result before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_record();
    int          pick;
    int          gap;
    int          rs_i;
    int          offset;
    int          slot;
    logic [5:0]  rf;
    logic [8:0]  df;
    logic [31:0] hi;
    pick = $urandom_range(999, 0);
    if (clears_left > 0 && pick < 4) begin
      clears_left--;
      send_record(pfsh_pkg::OP_CLEAR, $urandom, 1'($urandom), 6'($urandom), 9'($urandom),
                  6'($urandom), 9'($urandom));
    end else if (pick < 130) begin
      hi = (st_end > st_start) ? st_end - 1 : '1;
      send_record(pfsh_pkg::OP_TIME,
                  ($urandom_range(99, 0) < 85) ? $urandom_range(hi, st_start) : $urandom,
                  1'($urandom), 6'($urandom), 9'($urandom), 6'($urandom), 9'($urandom));
    end else if (pick < 740) begin
      if ($urandom_range(99, 0) < 85) begin
        // pair inside the ring limit and the fan, with random content
        rf = 6'($urandom);
        df = 9'($urandom);
        gap = $urandom_range(st_ring_diff, 0);
        rs_i = $urandom_range(1, 0) ? int'(rf) + gap : int'(rf) - gap;
        if (rs_i > 63) rs_i = 63;
        else if (rs_i < 0) rs_i = 0;
        offset = int'($urandom_range(2 * st_half_fan, 0)) - st_half_fan;
        recent_ring[recent_next] = rf;
        recent_det[recent_next] = df;
        recent_next = (recent_next + 1) % 16;
        send_record(pfsh_pkg::OP_EVENT, $urandom, st_prompts, rf, df, rs_i[5:0],
                    9'(int'(df) + 256 + offset));
      end else begin
        send_record(pfsh_pkg::OP_EVENT, $urandom, 1'($urandom), 6'($urandom), 9'($urandom),
                    6'($urandom), 9'($urandom));
      end
    end else begin
      if ($urandom_range(99, 0) < 75) begin
        slot = $urandom_range(15, 0);
        rf = recent_ring[slot];
        df = recent_det[slot];
      end else begin
        rf = 6'($urandom);
        df = 9'($urandom);
      end
      send_record(pfsh_pkg::OP_READ, $urandom, 1'($urandom), rf, df, 6'($urandom),
                  9'($urandom));
    end
  endtask

  task automatic run_phase(int items, int sender_pct, int receiver_pct);
    gap_pct = sender_pct;
    stall_pct = receiver_pct;
    // open the frame so that events can count from the start
    send_record(pfsh_pkg::OP_TIME, st_start, 1'b0, '0, '0, '0, '0);
    repeat (items) random_record();
    settle();
  endtask

  initial begin
    foreach (recent_ring[i]) begin
      recent_ring[i] = '0;
      recent_det[i] = '0;
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings: delayed events, full fan, widest ring gap
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b0, 6'd0, 9'd0, 6'd63, 9'd511);
    send_record(pfsh_pkg::OP_EVENT, '1, 1'b1, 6'd63, 9'd511, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_EVENT, 32'h5555_aaaa, 1'b0, 6'd5, 9'd100, 6'd5, 9'd100);
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, 6'd5, 9'd100, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_READ, '1, 1'b1, 6'd63, 9'd511, 6'd63, 9'd511);
    send_record(pfsh_pkg::OP_TIME, '1, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_TIME, '0, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    settle();

    // zero-width fan and ring gap, prompts only
    load_frame(32'd1000, '0, 0, 0, 1'b1);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b1, 6'd3, 9'd10, 6'd3, 9'd266);
    send_record(pfsh_pkg::OP_TIME, 32'd1000, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b1, 6'd3, 9'd10, 6'd3, 9'd266);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b1, 6'd3, 9'd10, 6'd4, 9'd266);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b1, 6'd3, 9'd10, 6'd3, 9'd267);
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, 6'd3, 9'd10, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_CLEAR, '0, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, 6'd3, 9'd10, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, 6'd3, 9'd266, 6'd0, 9'd0);
    settle();

    load_frame('0, '0, 63, 256, 1'b0);
    run_phase(150, 0, 0);
    load_frame($urandom, '0, $urandom_range(63, 0), $urandom_range(256, 0), 1'b1);
    run_phase(200, 84, 0);
    load_frame('1, '1, 0, 0, 1'b0);
    run_phase(150, 0, 84);
    // end below start leaves the frame open; fan wider than half the ring
    load_frame(32'h8000_0000 | $urandom, $urandom_range(32'h7fff_ffff, 0),
               $urandom_range(63, 0), 300, 1'($urandom_range(1, 0)));
    run_phase(200, 11, 11);
    load_frame($urandom_range(5000, 1000), '1, 2, 128, 1'b1);
    run_phase(250, 0, 0);

    // close the frame, then check that it stays closed
    send_record(pfsh_pkg::OP_TIME, '1, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b1, 6'd7, 9'd20, 6'd8, 9'd276);
    send_record(pfsh_pkg::OP_TIME, st_start, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_EVENT, '0, 1'b1, 6'd7, 9'd20, 6'd7, 9'd276);
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, recent_ring[0], recent_det[0], 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_CLEAR, '0, 1'b0, 6'd0, 9'd0, 6'd0, 9'd0);
    send_record(pfsh_pkg::OP_READ, '0, 1'b0, recent_ring[0], recent_det[0], 6'd0, 9'd0);
    settle();

    $display("Sent %0d records over seven register settings, ending with a closed frame;",
             n_records);
    $display("%0d events were counted and %0d reads returned a non-zero fan sum.",
             counted_events, nonzero_reads);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== pet_fan_sum_histogrammer_top.f =====
design/pfsh_pkg.sv
design/pfsh_ram.sv
design/pfsh_event_check.sv
design/pfsh_hist_ctrl.sv
design/pet_fan_sum_histogrammer_top.sv
tb/sv/fan_sum_checker.sv
tb/sv/tb_pet_fan_sum_histogrammer_top.sv
